/* hdl/ilpk_pkg.sv */
// ----------------------------------------------------------------------------
// ilpk_pkg: shared types and constants of the idle, lid and power key policy
// Event and command codes, request and result structs, configuration bundle.
// ----------------------------------------------------------------------------
package ilpk_pkg;

    localparam int NSTAGE           = 5;
    localparam int IDLE_W           = 26;
    localparam int AGE_W            = 10;
    localparam int CMD_W            = 4;
    localparam int NSLOT            = 8;
    localparam int SLOT_W           = 3;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 16;
    localparam int QDEPTH           = 2;
    localparam int QPTR_W           = 1;
    localparam int QCNT_W           = 2;
    localparam int TICKS_PER_SECOND = 1000;
    localparam int GRACE_TICKS      = 1000;

    localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};
    localparam logic [AGE_W-1:0]  AGE_MAX  = {AGE_W{1'b1}};

    // idle stage positions
    localparam int STG_DIM   = 0;
    localparam int STG_OFF   = 1;
    localparam int STG_LOCK  = 2;
    localparam int STG_SLEEP = 3;
    localparam int STG_SAVER = 4;

    typedef enum logic [2:0] {
        OP_TICK        = 3'd0,
        OP_ACTIVITY    = 3'd1,
        OP_INHIBIT     = 3'd2,
        OP_LID         = 3'd3,
        OP_KEY         = 3'd4,
        OP_SAVER_START = 3'd5,
        OP_SAVER_STOP  = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        ACT_DEFAULT    = 3'd0,
        ACT_NOTHING    = 3'd1,
        ACT_SLEEP      = 3'd2,
        ACT_HIBERNATE  = 3'd3,
        ACT_HYBRID     = 3'd4,
        ACT_LOCK       = 3'd5,
        ACT_SCREEN_OFF = 3'd6,
        ACT_SHUTDOWN   = 3'd7
    } act_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_NONE       = 4'd0,
        CMD_DIM        = 4'd1,
        CMD_UNDIM      = 4'd2,
        CMD_OFF        = 4'd3,
        CMD_ON         = 4'd4,
        CMD_LOCK       = 4'd5,
        CMD_SUSPEND    = 4'd6,
        CMD_HIBERNATE  = 4'd7,
        CMD_HYBRID     = 4'd8,
        CMD_POWEROFF   = 4'd9,
        CMD_SAVER_ON   = 4'd10,
        CMD_SAVER_END  = 4'd11,
        CMD_PANEL_OFF  = 4'd12,
        CMD_PANEL_ON   = 4'd13
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIM_TIMEOUT   = 3'd0,
        REG_OFF_TIMEOUT   = 3'd1,
        REG_LOCK_TIMEOUT  = 3'd2,
        REG_SLEEP_TIMEOUT = 3'd3,
        REG_SAVER_TIMEOUT = 3'd4,
        REG_LID_ACTIONS   = 3'd5,
        REG_KEY_ACTION    = 3'd6,
        REG_SAVER_LOCK    = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [2:0] operation;
        logic       flag;
        logic       docked;
        logic       internal_enabled;
    } in_item_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             handled;
        logic             last;
    } out_item_t;

    // Timeouts are held already scaled to ticks; zero still means never.
    typedef struct packed {
        logic [NSTAGE-1:0][IDLE_W-1:0] limit;
        logic [5:0]                    lid_actions;
        logic [2:0]                    key_action;
        logic                          saver_lock;
    } cfg_t;

    // Classified request handed from the front to the back.
    typedef struct packed {
        op_t  kind;
        logic flag;
        logic panel_target;
        logic lid_en;
        logic key_en;
        cmd_t act_cmd;
        logic act_off;
    } evt_t;

    function automatic cmd_t action_cmd(input act_t a);
        cmd_t c;
        c = CMD_NONE;
        unique case (a)
            ACT_SLEEP:     c = CMD_SUSPEND;
            ACT_HIBERNATE: c = CMD_HIBERNATE;
            ACT_HYBRID:    c = CMD_HYBRID;
            ACT_LOCK:      c = CMD_LOCK;
            ACT_SHUTDOWN:  c = CMD_POWEROFF;
            default:       c = CMD_NONE;
        endcase
        return c;
    endfunction

endpackage

/* hdl/ilpk_front.sv */
// ----------------------------------------------------------------------------
// ilpk_front: request intake and classification
// Registers one request, resolves its lid or key action and pushes it on.
// ----------------------------------------------------------------------------
module ilpk_front
    import ilpk_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_data,
    input  cfg_t     cfg,
    input  logic     q_full,
    output logic     push,
    output evt_t     push_evt
);

    logic     f_valid_reg;
    in_item_t f_item_reg;
    act_t     lid_act;
    act_t     sel_act;
    op_t      kind;

    assign in_stall = f_valid_reg && q_full;
    assign push     = f_valid_reg && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            f_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            f_item_reg <= in_data;
        end
    end

    // Resolve the lid action for the dock state; default means sleep undocked.
    always_comb
    begin
        kind    = op_t'(f_item_reg.operation);
        lid_act = f_item_reg.docked ? act_t'(cfg.lid_actions[5:3])
                                    : act_t'(cfg.lid_actions[2:0]);
        if (lid_act == ACT_DEFAULT)
        begin
            lid_act = f_item_reg.docked ? ACT_NOTHING : ACT_SLEEP;
        end
        sel_act = (kind == OP_LID) ? lid_act : act_t'(cfg.key_action);

        push_evt.kind         = kind;
        push_evt.flag         = f_item_reg.flag;
        push_evt.panel_target = f_item_reg.docked && f_item_reg.internal_enabled;
        push_evt.lid_en       = (cfg.lid_actions != '0);
        push_evt.key_en       = (act_t'(cfg.key_action) != ACT_DEFAULT);
        push_evt.act_cmd      = action_cmd(sel_act);
        push_evt.act_off      = (sel_act == ACT_SCREEN_OFF);
    end

endmodule

/* hdl/ilpk_queue.sv */
// ----------------------------------------------------------------------------
// ilpk_queue: short request queue between front and back
// Two-entry FIFO of classified requests.
// ----------------------------------------------------------------------------
module ilpk_queue
    import ilpk_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  evt_t push_evt,
    input  logic pop,
    output evt_t head,
    output logic q_valid,
    output logic q_full
);

    evt_t              q_mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign head    = q_mem_reg[rd_ptr_reg];
    assign q_valid = (count_reg != '0);
    assign q_full  = (count_reg == QCNT_W'(QDEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= push_evt;
        end
    end

    // Depth is a power of two, so the pointers wrap on their own.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + QCNT_W'(1);
                2'b01:   count_reg <= count_reg - QCNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

/* hdl/ilpk_back.sv */
// ----------------------------------------------------------------------------
// ilpk_back: policy state, request execution and command issue
// Executes one request per cycle into a slot list once the last list drained,
// then issues one command per cycle, unless stalled, via the output register.
// ----------------------------------------------------------------------------
module ilpk_back
    import ilpk_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      q_valid,
    input  evt_t      q_evt,
    output logic      q_pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    // policy state
    logic [IDLE_W-1:0] idle_ms_reg, idle_ms_next;
    logic [NSTAGE-1:0] fired_reg, fired_next;
    logic              inhibited_reg, inhibited_next;
    logic              dimmed_reg, dimmed_next;
    logic              iso_reg, iso_next;
    logic              lid_closed_reg, lid_closed_next;
    logic              lso_reg, lso_next;
    logic              panel_dis_reg, panel_dis_next;
    logic              saver_run_reg, saver_run_next;
    logic              saver_man_reg, saver_man_next;
    logic [AGE_W-1:0]  saver_age_reg, saver_age_next;

    // command slot list
    cmd_t              slot_cmd [NSLOT];
    logic [NSLOT-1:0]  slot_mask;
    logic              slot_handled;
    cmd_t              list_cmd_reg [NSLOT];
    logic [NSLOT-1:0]  list_mask_reg;
    logic              list_handled_reg;

    logic              out_valid_reg;
    out_item_t         out_data_reg;

    logic [IDLE_W-1:0] idle_inc;
    logic [AGE_W-1:0]  age_inc;
    logic [NSTAGE-1:0] hit;
    logic              do_wake;
    logic              in_grace;
    logic [SLOT_W-1:0] sel;
    logic [NSLOT-1:0]  sel_onehot;
    logic [NSLOT-1:0]  mask_rest;
    logic              out_load;
    logic              list_drained;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign idle_inc = (idle_ms_reg == IDLE_MAX) ? idle_ms_reg : idle_ms_reg + IDLE_W'(1);
    assign age_inc  = (saver_run_reg && saver_age_reg != AGE_MAX)
                    ? saver_age_reg + AGE_W'(1) : saver_age_reg;
    assign in_grace = saver_man_reg && saver_run_reg
                   && (saver_age_reg < AGE_W'(GRACE_TICKS));

    always_comb
    begin
        for (int s = 0; s < NSTAGE; s++)
        begin
            hit[s] = (cfg.limit[s] != '0) && !fired_reg[s] && (idle_inc >= cfg.limit[s]);
        end
    end

    // Execute the head request against the state.
    always_comb
    begin
        idle_ms_next    = idle_ms_reg;
        fired_next      = fired_reg;
        inhibited_next  = inhibited_reg;
        dimmed_next     = dimmed_reg;
        iso_next        = iso_reg;
        lid_closed_next = lid_closed_reg;
        lso_next        = lso_reg;
        panel_dis_next  = panel_dis_reg;
        saver_run_next  = saver_run_reg;
        saver_man_next  = saver_man_reg;
        saver_age_next  = saver_age_reg;
        slot_mask       = '0;
        slot_handled    = 1'b0;
        do_wake         = 1'b0;
        for (int i = 0; i < NSLOT; i++)
        begin
            slot_cmd[i] = CMD_NONE;
        end

        unique case (q_evt.kind)
            OP_TICK:
            begin
                idle_ms_next   = idle_inc;
                saver_age_next = age_inc;
                if (!inhibited_reg)
                begin
                    if (hit[STG_DIM])
                    begin
                        dimmed_next = 1'b1;
                        slot_mask[0] = 1'b1;
                        slot_cmd[0]  = CMD_DIM;
                    end
                    if (hit[STG_OFF])
                    begin
                        if (saver_run_next)
                        begin
                            saver_run_next = 1'b0;
                            saver_man_next = 1'b0;
                            slot_mask[1]   = 1'b1;
                            slot_cmd[1]    = CMD_SAVER_END;
                        end
                        slot_mask[2] = 1'b1;
                        slot_cmd[2]  = CMD_OFF;
                        iso_next     = 1'b1;
                    end
                    if (hit[STG_LOCK])
                    begin
                        if (saver_run_next)
                        begin
                            saver_run_next = 1'b0;
                            saver_man_next = 1'b0;
                            slot_mask[3]   = 1'b1;
                            slot_cmd[3]    = CMD_SAVER_END;
                        end
                        slot_mask[4] = 1'b1;
                        slot_cmd[4]  = CMD_LOCK;
                    end
                    if (hit[STG_SLEEP])
                    begin
                        if (saver_run_next)
                        begin
                            saver_run_next = 1'b0;
                            saver_man_next = 1'b0;
                            slot_mask[5]   = 1'b1;
                            slot_cmd[5]    = CMD_SAVER_END;
                        end
                        slot_mask[6] = 1'b1;
                        slot_cmd[6]  = CMD_SUSPEND;
                    end
                    // saver stage launches nothing once screens went off
                    if (hit[STG_SAVER] && !iso_next && !saver_run_next)
                    begin
                        saver_run_next = 1'b1;
                        saver_age_next = '0;
                        slot_mask[7]   = 1'b1;
                        slot_cmd[7]    = CMD_SAVER_ON;
                    end
                    fired_next = fired_reg | hit;
                end
            end
            OP_ACTIVITY:
            begin
                idle_ms_next = '0;
                do_wake      = !in_grace && (fired_reg != '0);
            end
            OP_INHIBIT:
            begin
                if (q_evt.flag != inhibited_reg)
                begin
                    inhibited_next = q_evt.flag;
                    idle_ms_next   = '0;
                    do_wake        = q_evt.flag;
                end
            end
            OP_LID:
            begin
                if (q_evt.flag != lid_closed_reg)
                begin
                    lid_closed_next = q_evt.flag;
                    if (q_evt.lid_en && !q_evt.flag)
                    begin
                        if (panel_dis_reg)
                        begin
                            panel_dis_next = 1'b0;
                            slot_mask[0]   = 1'b1;
                            slot_cmd[0]    = CMD_PANEL_ON;
                        end
                        if (lso_reg)
                        begin
                            lso_next     = 1'b0;
                            slot_mask[1] = 1'b1;
                            slot_cmd[1]  = CMD_ON;
                        end
                    end
                    else if (q_evt.lid_en && q_evt.act_off)
                    begin
                        slot_mask[0] = 1'b1;
                        if (q_evt.panel_target)
                        begin
                            panel_dis_next = 1'b1;
                            slot_cmd[0]    = CMD_PANEL_OFF;
                        end
                        else
                        begin
                            lso_next    = 1'b1;
                            slot_cmd[0] = CMD_OFF;
                        end
                    end
                    else if (q_evt.lid_en && q_evt.act_cmd != CMD_NONE)
                    begin
                        slot_mask[0] = 1'b1;
                        slot_cmd[0]  = q_evt.act_cmd;
                    end
                end
            end
            OP_KEY:
            begin
                // always exactly one reply
                slot_mask[0] = 1'b1;
                slot_handled = q_evt.key_en;
                if (q_evt.key_en && q_evt.flag)
                begin
                    if (q_evt.act_off)
                    begin
                        iso_next    = 1'b1;
                        slot_cmd[0] = CMD_OFF;
                    end
                    else
                    begin
                        slot_cmd[0] = q_evt.act_cmd;
                    end
                end
            end
            OP_SAVER_START:
            begin
                if (!saver_run_reg)
                begin
                    saver_run_next        = 1'b1;
                    saver_man_next        = 1'b1;
                    saver_age_next        = '0;
                    fired_next[STG_SAVER] = 1'b1;
                    slot_mask[0]          = 1'b1;
                    slot_cmd[0]           = CMD_SAVER_ON;
                end
            end
            OP_SAVER_STOP:
            begin
                if (saver_run_reg)
                begin
                    saver_run_next = 1'b0;
                    saver_man_next = 1'b0;
                    slot_mask[0]   = 1'b1;
                    slot_cmd[0]    = CMD_SAVER_END;
                end
                fired_next[STG_SAVER] = 1'b0;
            end
            default:
            begin
            end
        endcase

        // wake: end saver, lock if set, undim, screens on unless lid off, rearm all
        if (do_wake)
        begin
            if (saver_run_reg)
            begin
                saver_run_next = 1'b0;
                saver_man_next = 1'b0;
                slot_mask[0]   = 1'b1;
                slot_cmd[0]    = CMD_SAVER_END;
                if (cfg.saver_lock)
                begin
                    slot_mask[1] = 1'b1;
                    slot_cmd[1]  = CMD_LOCK;
                end
            end
            if (dimmed_reg)
            begin
                dimmed_next  = 1'b0;
                slot_mask[2] = 1'b1;
                slot_cmd[2]  = CMD_UNDIM;
            end
            if (iso_reg)
            begin
                iso_next = 1'b0;
                if (!lso_reg)
                begin
                    slot_mask[3] = 1'b1;
                    slot_cmd[3]  = CMD_ON;
                end
            end
            fired_next = '0;
        end
    end

    // Pick the lowest pending slot.
    always_comb
    begin
        sel = '0;
        for (int i = NSLOT - 1; i >= 0; i--)
        begin
            if (list_mask_reg[i])
            begin
                sel = SLOT_W'(i);
            end
        end
    end

    assign sel_onehot   = NSLOT'(1) << sel;
    assign mask_rest    = list_mask_reg & ~sel_onehot;
    assign out_load     = (list_mask_reg != '0) && (!out_valid_reg || !out_stall);
    assign list_drained = (list_mask_reg == '0) || (out_load && mask_rest == '0);
    assign q_pop        = q_valid && list_drained;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_ms_reg    <= '0;
            fired_reg      <= '0;
            inhibited_reg  <= 1'b0;
            dimmed_reg     <= 1'b0;
            iso_reg        <= 1'b0;
            lid_closed_reg <= 1'b0;
            lso_reg        <= 1'b0;
            panel_dis_reg  <= 1'b0;
            saver_run_reg  <= 1'b0;
            saver_man_reg  <= 1'b0;
            saver_age_reg  <= '0;
            list_mask_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                idle_ms_reg    <= idle_ms_next;
                fired_reg      <= fired_next;
                inhibited_reg  <= inhibited_next;
                dimmed_reg     <= dimmed_next;
                iso_reg        <= iso_next;
                lid_closed_reg <= lid_closed_next;
                lso_reg        <= lso_next;
                panel_dis_reg  <= panel_dis_next;
                saver_run_reg  <= saver_run_next;
                saver_man_reg  <= saver_man_next;
                saver_age_reg  <= saver_age_next;
                list_mask_reg  <= slot_mask;
            end
            else if (out_load)
            begin
                list_mask_reg <= mask_rest;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            list_cmd_reg     <= slot_cmd;
            list_handled_reg <= slot_handled;
        end
        if (out_load)
        begin
            out_data_reg.command <= list_cmd_reg[sel];
            out_data_reg.handled <= list_handled_reg;
            out_data_reg.last    <= (mask_rest == '0);
        end
    end

    a_manual_implies_running: assert property (@(posedge clk) disable iff (!rst_n)
        !saver_man_reg || saver_run_reg)
        else $error("manual saver flag set without a running saver");

    a_dim_implies_fired: assert property (@(posedge clk) disable iff (!rst_n)
        !dimmed_reg || fired_reg[STG_DIM])
        else $error("dimmed without the dim stage marked fired");

    a_key_one_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_evt.kind == OP_KEY) |=> ($countones(list_mask_reg) == 1))
        else $error("power key request did not yield exactly one reply");

    a_idle_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_evt.kind == OP_TICK && idle_ms_reg == IDLE_MAX)
        |=> (idle_ms_reg == IDLE_MAX))
        else $error("idle counter wrapped");

endmodule

/* hdl/idle_lid_power_key_policy_top.sv */
// ----------------------------------------------------------------------------
// idle_lid_power_key_policy_top: idle, lid and power key policy engine
// Counts idle ticks, fires the idle stages and maps lid and key events to
// display, lock, saver and power commands.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one event request
//   per handshake: tick, activity, inhibit, lid, key, saver start or stop.
//   Output channel (out_valid / out_stall / out_data) returns the commands
//   the request causes, in order, one per cycle unless stalled; last marks
//   the final one. A power key request always returns exactly one result;
//   requests that cause no command return nothing.
//   Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) is always
//   ready; write it only while no request is in flight.
// Timing:
//   The first result passes the front register, the queue, the slot list
//   and the output register. The back end executes one request per cycle
//   once the last one's commands are out and issues one per cycle unless
//   stalled. A front register and a two-entry queue keep taking requests
//   while results wait on a stalled receiver; out_data holds while stalled.
// Reset:
//   Clears all policy state and configuration; no clearing pass needed.
// ----------------------------------------------------------------------------
module idle_lid_power_key_policy_top
    import ilpk_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t              cfg_reg;
    logic              cfg_we;
    logic [IDLE_W-1:0] cfg_limit;

    logic              push;
    evt_t              push_evt;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;
    evt_t              q_head;

    // Registers are always writable.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // Scale timeouts to ticks at write time so the compare path stays short.
    assign cfg_limit = IDLE_W'(cfg_data) * IDLE_W'(TICKS_PER_SECOND);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index)) inside
                REG_DIM_TIMEOUT, REG_OFF_TIMEOUT, REG_LOCK_TIMEOUT,
                REG_SLEEP_TIMEOUT, REG_SAVER_TIMEOUT:
                    cfg_reg.limit[cfg_index] <= cfg_limit;
                REG_LID_ACTIONS:
                    cfg_reg.lid_actions <= cfg_data[5:0];
                REG_KEY_ACTION:
                    cfg_reg.key_action <= cfg_data[2:0];
                REG_SAVER_LOCK:
                    cfg_reg.saver_lock <= cfg_data[0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Front: take and classify the request.
    ilpk_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .push     (push),
        .push_evt (push_evt)
    );

    // Queue: decouple intake from command issue.
    ilpk_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_evt (push_evt),
        .pop      (q_pop),
        .head     (q_head),
        .q_valid  (q_valid),
        .q_full   (q_full)
    );

    // Back: advance the policy state and issue the commands.
    ilpk_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_evt     (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

/* verif/tb_idle_lid_power_key_policy_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_idle_lid_power_key_policy_top: self-checking bench for the policy engine
// Walks a short directed table, then four phases of random events mixed with
// short tick bursts. Each phase uses its own idling pattern. Every result is
// checked in order against a typed value or a bench idle, lid, key model.
// ----------------------------------------------------------------------------
module tb_idle_lid_power_key_policy_top;
    import ilpk_pkg::*;

    // Operation code with no meaning to the block; it must be dropped silently.
    localparam logic [2:0] OP_UNUSED = 3'd7;

    localparam int  MAX_CMDS         = 8;
    localparam int  BY_MODEL         = -1;  // row is checked against the model
    localparam int  NO_ROW           = -1;  // request is not from the table
    localparam int  DRAIN_GAP        = 16;  // cycles beyond the last result
    localparam int  HOLD_LEN         = 150; // long receiver hold-off
    localparam int  PRESSURE_REQS    = 24;
    localparam int  EVENTS_PER_PHASE = 10;
    localparam int  NPHASE           = 4;
    localparam bit  ROW_REQ          = 1'b0;
    localparam bit  ROW_CFG          = 1'b1;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    idle_lid_power_key_policy_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Directed table. A row either writes one register or offers one request.
    // Where the outcome is obvious (reset state, unhandled key, extremes) the
    // result is typed in; all other rows are checked against the model.
    // ------------------------------------------------------------------------
    typedef struct {
        bit          kind;
        reg_idx_t    idx;
        logic [15:0] val;
        in_item_t    req;
        int          n_typed;
        cmd_t        cmd;
        logic        handled;
    } plan_row_t;

    localparam int NPLAN = 35;

    plan_row_t plan [NPLAN] = '{
        // reset configuration: every timeout off, no lid or key action
        '{ROW_REQ, REG_DIM_TIMEOUT, 16'd0, '{OP_TICK,        1'b0, 1'b0, 1'b0}, 0, CMD_NONE, 1'b0},
        '{ROW_REQ, REG_DIM_TIMEOUT, 16'd0, '{OP_KEY,         1'b1, 1'b0, 1'b0}, 1, CMD_NONE, 1'b0},
        '{ROW_REQ, REG_DIM_TIMEOUT, 16'd0, '{OP_KEY,         1'b0, 1'b1, 1'b1}, 1, CMD_NONE, 1'b0},
        '{ROW_REQ, REG_DIM_TIMEOUT, 16'd0, '{OP_UNUSED,      1'b1, 1'b1, 1'b1}, 0, CMD_NONE, 1'b0},
        // lid closed is recorded although no lid action is set
        '{ROW_REQ, REG_DIM_TIMEOUT, 16'd0, '{OP_LID,         1'b1, 1'b1, 1'b1}, 0, CMD_NONE, 1'b0},
        '{ROW_REQ, REG_DIM_TIMEOUT, 16'd0, '{OP_ACTIVITY,    1'b0, 1'b0, 1'b0}, 0, CMD_NONE, 1'b0},
        // inhibit unchanged, then set
        '{ROW_REQ, REG_DIM_TIMEOUT, 16'd0, '{OP_INHIBIT,     1'b0, 1'b0, 1'b0}, 0, CMD_NONE, 1'b0},
        '{ROW_REQ, REG_DIM_TIMEOUT, 16'd0, '{OP_INHIBIT,     1'b1, 1'b0, 1'b0}, 0, CMD_NONE, 1'b0},
        // manual saver, second start ignored, activity inside the grace window
        '{ROW_REQ, REG_DIM_TIMEOUT, 16'd0, '{OP_SAVER_START, 1'b0, 1'b0, 1'b0}, 1, CMD_SAVER_ON, 1'b0},
        '{ROW_REQ, REG_DIM_TIMEOUT, 16'd0, '{OP_SAVER_START, 1'b1, 1'b1, 1'b0}, 0, CMD_NONE, 1'b0},
        '{ROW_REQ, REG_DIM_TIMEOUT, 16'd0, '{OP_ACTIVITY,    1'b1, 1'b0, 1'b1}, 0, CMD_NONE, 1'b0},
        '{ROW_REQ, REG_DIM_TIMEOUT, 16'd0, '{OP_SAVER_STOP,  1'b0, 1'b0, 1'b0}, 1, CMD_SAVER_END, 1'b0},
        '{ROW_REQ, REG_DIM_TIMEOUT, 16'd0, '{OP_INHIBIT,     1'b0, 1'b1, 1'b1}, 0, CMD_NONE, 1'b0},
        // screen-off actions, lock on saver end
        '{ROW_CFG, REG_KEY_ACTION,  16'(ACT_SCREEN_OFF), '0, BY_MODEL, CMD_NONE, 1'b0},
        '{ROW_CFG, REG_LID_ACTIONS, 16'({ACT_SCREEN_OFF, ACT_DEFAULT}), '0, BY_MODEL, CMD_NONE, 1'b0},
        '{ROW_CFG, REG_SAVER_LOCK,  16'd1, '0, BY_MODEL, CMD_NONE, 1'b0},
        '{ROW_REQ, REG_DIM_TIMEOUT, 16'd0, '{OP_LID,         1'b0, 1'b1, 1'b1}, BY_MODEL, CMD_NONE, 1'b0},
        '{ROW_REQ, REG_DIM_TIMEOUT, 16'd0, '{OP_KEY,         1'b1, 1'b0, 1'b0}, 1, CMD_OFF, 1'b1},
        '{ROW_REQ, REG_DIM_TIMEOUT, 16'd0, '{OP_KEY,         1'b0, 1'b0, 1'b0}, 1, CMD_NONE, 1'b1},
        '{ROW_REQ, REG_DIM_TIMEOUT, 16'd0, '{OP_LID,         1'b1, 1'b1, 1'b1}, BY_MODEL, CMD_NONE, 1'b0},
        '{ROW_REQ, REG_DIM_TIMEOUT, 16'd0, '{OP_LID,         1'b0, 1'b1, 1'b1}, BY_MODEL, CMD_NONE, 1'b0},
        // default lid action while undocked
        '{ROW_REQ, REG_DIM_TIMEOUT, 16'd0, '{OP_LID,         1'b1, 1'b0, 1'b1}, BY_MODEL, CMD_NONE, 1'b0},
        '{ROW_REQ, REG_DIM_TIMEOUT, 16'd0, '{OP_LID,         1'b0, 1'b0, 1'b1}, BY_MODEL, CMD_NONE, 1'b0},
        '{ROW_REQ, REG_DIM_TIMEOUT, 16'd0, '{OP_LID,         1'b1, 1'b1, 1'b0}, BY_MODEL, CMD_NONE, 1'b0},
        '{ROW_REQ, REG_DIM_TIMEOUT, 16'd0, '{OP_SAVER_START, 1'b0, 1'b1, 1'b0}, BY_MODEL, CMD_NONE, 1'b0},
        '{ROW_REQ, REG_DIM_TIMEOUT, 16'd0, '{OP_INHIBIT,     1'b1, 1'b1, 1'b0}, BY_MODEL, CMD_NONE, 1'b0},
        '{ROW_REQ, REG_DIM_TIMEOUT, 16'd0, '{OP_LID,         1'b0, 1'b0, 1'b0}, BY_MODEL, CMD_NONE, 1'b0},
        // extremes of every register
        '{ROW_CFG, REG_DIM_TIMEOUT,   16'hFFFF, '0, BY_MODEL, CMD_NONE, 1'b0},
        '{ROW_CFG, REG_OFF_TIMEOUT,   16'hFFFF, '0, BY_MODEL, CMD_NONE, 1'b0},
        '{ROW_CFG, REG_LOCK_TIMEOUT,  16'hFFFF, '0, BY_MODEL, CMD_NONE, 1'b0},
        '{ROW_CFG, REG_SLEEP_TIMEOUT, 16'hFFFF, '0, BY_MODEL, CMD_NONE, 1'b0},
        '{ROW_CFG, REG_SAVER_TIMEOUT, 16'hFFFF, '0, BY_MODEL, CMD_NONE, 1'b0},
        '{ROW_CFG, REG_LID_ACTIONS, 16'({ACT_SHUTDOWN, ACT_SHUTDOWN}), '0, BY_MODEL, CMD_NONE, 1'b0},
        '{ROW_CFG, REG_KEY_ACTION,  16'(ACT_SHUTDOWN), '0, BY_MODEL, CMD_NONE, 1'b0},
        '{ROW_CFG, REG_SAVER_LOCK,  16'd0, '0, BY_MODEL, CMD_NONE, 1'b0}
    };

    // Two requests run against the extreme settings after the table.
    plan_row_t tail_rows [2] = '{
        '{ROW_REQ, REG_DIM_TIMEOUT, 16'd0, '{OP_KEY, 1'b1, 1'b1, 1'b1}, 1, CMD_POWEROFF, 1'b1},
        '{ROW_REQ, REG_DIM_TIMEOUT, 16'd0, '{OP_LID, 1'b1, 1'b0, 1'b0}, 1, CMD_POWEROFF, 1'b0}
    };

    // ------------------------------------------------------------------------
    // Policy model: configuration and state as seen from outside the block
    // ------------------------------------------------------------------------
    logic [15:0]       tmo_s [NSTAGE] = '{default: '0};
    logic [5:0]        lid_act     = '0;
    logic [2:0]        key_act     = '0;
    logic              lock_on_end = 1'b0;

    logic [IDLE_W-1:0] idle_ticks  = '0;
    logic [NSTAGE-1:0] fired       = '0;
    logic              inhib       = 1'b0;
    logic              dim_on      = 1'b0;
    logic              idle_off    = 1'b0;
    logic              lid_shut    = 1'b0;
    logic              lid_off     = 1'b0;
    logic              panel_off   = 1'b0;
    logic              saver_on    = 1'b0;
    logic              saver_man   = 1'b0;
    logic [AGE_W-1:0]  saver_age   = '0;

    cmd_t              step_cmds [$];
    logic              step_handled;
    out_item_t         due_results [$];
    out_item_t         oldest_due;

    function automatic void add_cmd(input cmd_t c);
        if (step_cmds.size() < MAX_CMDS)
            step_cmds.push_back(c);
    endfunction

    function automatic bit end_saver();
        if (!saver_on)
            return 1'b0;
        saver_on  = 1'b0;
        saver_man = 1'b0;
        add_cmd(CMD_SAVER_END);
        return 1'b1;
    endfunction

    function automatic void begin_saver();
        if (saver_on)
            return;
        saver_on  = 1'b1;
        saver_age = '0;
        add_cmd(CMD_SAVER_ON);
    endfunction

    function automatic void fire_stage(input int s);
        case (s)
            STG_DIM:
            begin
                dim_on = 1'b1;
                add_cmd(CMD_DIM);
            end
            STG_OFF:
            begin
                void'(end_saver());
                add_cmd(CMD_OFF);
                idle_off = 1'b1;
            end
            STG_LOCK:
            begin
                void'(end_saver());
                add_cmd(CMD_LOCK);
            end
            STG_SLEEP:
            begin
                void'(end_saver());
                add_cmd(CMD_SUSPEND);
            end
            default:
                if (!idle_off)
                    begin_saver();
        endcase
    endfunction

    function automatic void wake_up();
        if (end_saver() && lock_on_end)
            add_cmd(CMD_LOCK);
        if (dim_on)
        begin
            dim_on = 1'b0;
            add_cmd(CMD_UNDIM);
        end
        if (idle_off)
        begin
            idle_off = 1'b0;
            if (!lid_off)
                add_cmd(CMD_ON);
        end
        fired = '0;
    endfunction

    // Lid and key action; returns 0 when the action is screen off.
    function automatic bit apply_action(input act_t a);
        case (a)
            ACT_SLEEP:      add_cmd(CMD_SUSPEND);
            ACT_HIBERNATE:  add_cmd(CMD_HIBERNATE);
            ACT_HYBRID:     add_cmd(CMD_HYBRID);
            ACT_LOCK:       add_cmd(CMD_LOCK);
            ACT_SCREEN_OFF: return 1'b0;
            ACT_SHUTDOWN:   add_cmd(CMD_POWEROFF);
            default:        ;
        endcase
        return 1'b1;
    endfunction

    // Advance the model by one request; leaves its commands in step_cmds.
    function automatic void policy_step(input in_item_t r);
        logic [31:0] lim;
        act_t        a;
        int          s;
        step_cmds.delete();
        step_handled = 1'b0;
        case (r.operation)
            OP_TICK:
            begin
                if (idle_ticks != IDLE_MAX)
                    idle_ticks++;
                if (saver_on && saver_age != AGE_MAX)
                    saver_age++;
                if (!inhib)
                    for (s = 0; s < NSTAGE; s++)
                    begin
                        lim = 32'(tmo_s[s]) * TICKS_PER_SECOND;
                        if (tmo_s[s] != 0 && !fired[s] && 32'(idle_ticks) >= lim)
                        begin
                            fired[s] = 1'b1;
                            fire_stage(s);
                        end
                    end
            end
            OP_ACTIVITY:
            begin
                idle_ticks = '0;
                // inside the grace window of a manual saver nothing else happens
                if (!(saver_man && saver_on && saver_age < GRACE_TICKS) && |fired)
                    wake_up();
            end
            OP_INHIBIT:
                if (r.flag != inhib)
                begin
                    inhib = r.flag;
                    if (r.flag)
                        wake_up();
                    idle_ticks = '0;
                end
            OP_LID:
                if (r.flag != lid_shut)
                begin
                    lid_shut = r.flag;
                    if (lid_act != 0)
                    begin
                        if (!r.flag)
                        begin
                            if (panel_off)
                            begin
                                panel_off = 1'b0;
                                add_cmd(CMD_PANEL_ON);
                            end
                            if (lid_off)
                            begin
                                lid_off = 1'b0;
                                add_cmd(CMD_ON);
                            end
                        end
                        else
                        begin
                            a = act_t'(r.docked ? lid_act[5:3] : lid_act[2:0]);
                            if (a == ACT_DEFAULT)
                                a = r.docked ? ACT_NOTHING : ACT_SLEEP;
                            if (!apply_action(a))
                            begin
                                if (r.docked && r.internal_enabled)
                                begin
                                    panel_off = 1'b1;
                                    add_cmd(CMD_PANEL_OFF);
                                end
                                else
                                begin
                                    lid_off = 1'b1;
                                    add_cmd(CMD_OFF);
                                end
                            end
                        end
                    end
                end
            OP_KEY:
            begin
                if (key_act != ACT_DEFAULT)
                begin
                    step_handled = 1'b1;
                    if (r.flag && !apply_action(act_t'(key_act)))
                    begin
                        idle_off = 1'b1;
                        add_cmd(CMD_OFF);
                    end
                end
                // a key request always answers, even with no command
                if (step_cmds.size() == 0)
                    add_cmd(CMD_NONE);
            end
            OP_SAVER_START:
                if (!saver_on)
                begin
                    begin_saver();
                    saver_man        = 1'b1;
                    fired[STG_SAVER] = 1'b1;
                end
            OP_SAVER_STOP:
            begin
                void'(end_saver());
                fired[STG_SAVER] = 1'b0;
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    int err_count = 0;

    function automatic void note_mismatch(input string what, input out_item_t want,
                                          input out_item_t got);
        err_count++;
        if (err_count <= 10)
            $display("%0t %s: want cmd %0d handled %0b last %0b, got cmd %0d handled %0b last %0b",
                     $realtime, what, want.command, want.handled, want.last,
                     got.command, got.handled, got.last);
    endfunction

    // Tag travelling with the request: which table row it came from, if any.
    int        row_tag = NO_ROW;
    plan_row_t tagged_row;

    // Sample everything on the rising edge, before the edge's own updates land.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // register write: mirror it into the model's configuration
            if (cfg_valid && cfg_ready)
            begin
                case (reg_idx_t'(cfg_index)) inside
                    REG_DIM_TIMEOUT, REG_OFF_TIMEOUT, REG_LOCK_TIMEOUT,
                    REG_SLEEP_TIMEOUT, REG_SAVER_TIMEOUT:
                        tmo_s[cfg_index] = cfg_data;
                    REG_LID_ACTIONS: lid_act     = cfg_data[5:0];
                    REG_KEY_ACTION:  key_act     = cfg_data[2:0];
                    default:         lock_on_end = cfg_data[0];
                endcase
            end

            // accepted request: advance the model, queue what it must produce
            if (in_valid && !in_stall)
            begin
                policy_step(in_data);
                if (row_tag >= NPLAN)
                    tagged_row = tail_rows[row_tag - NPLAN];
                else if (row_tag != NO_ROW)
                    tagged_row = plan[row_tag];
                if (row_tag != NO_ROW && tagged_row.n_typed != BY_MODEL)
                begin
                    if (tagged_row.n_typed == 1)
                        due_results.push_back('{command: tagged_row.cmd,
                                                handled: tagged_row.handled,
                                                last:    1'b1});
                end
                else
                    foreach (step_cmds[i])
                        due_results.push_back('{command: step_cmds[i],
                                                handled: step_handled,
                                                last:    i == step_cmds.size() - 1});
            end

            // accepted result: compare with the oldest one still due
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                    note_mismatch("unexpected result", '0, out_data);
                else
                begin
                    oldest_due = due_results.pop_front();
                    if (out_data.command !== oldest_due.command ||
                        out_data.handled !== oldest_due.handled ||
                        out_data.last    !== oldest_due.last)
                        note_mismatch("result mismatch", oldest_due, out_data);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off counted here
    // ------------------------------------------------------------------------
    int   gap_pct    = 0;
    int   stall_pct  = 0;
    logic hold_arm   = 1'b0;
    int   hold_count = 0;

    always @(posedge clk)
    begin
        if (hold_arm && hold_count < HOLD_LEN)
        begin
            out_stall  <= 1'b1;
            hold_count <= hold_count + 1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    bit cfg_open = 1'b0;

    // Offer one request, idling first at random; hold it until it is taken.
    task automatic offer(input in_item_t req, input int tag);
        if (cfg_open)
        begin
            cfg_valid <= 1'b0;
            cfg_open = 1'b0;
        end
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        row_tag  <= tag;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drop valid, wait for every due result, then let the pipe run dry.
    task automatic settle();
        in_valid <= 1'b0;
        if (cfg_open)
        begin
            cfg_valid <= 1'b0;
            cfg_open = 1'b0;
        end
        @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_GAP)
            @(posedge clk);
    endtask

    // Write one register; valid is left up so back-to-back writes stay clean.
    task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_open = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    function automatic in_item_t random_req(input logic [2:0] op);
        in_item_t r;
        r.operation        = op;
        r.flag             = 1'($urandom_range(1));
        r.docked           = 1'($urandom_range(1));
        r.internal_enabled = 1'($urandom_range(1));
        return r;
    endfunction

    // Weighted pick: activity most often, the unused code rarely.
    function automatic logic [2:0] pick_op();
        int roll;
        roll = $urandom_range(19);
        if (roll < 6)
            return OP_ACTIVITY;
        else if (roll < 8)
            return OP_INHIBIT;
        else if (roll < 11)
            return OP_LID;
        else if (roll < 14)
            return OP_KEY;
        else if (roll < 16)
            return OP_SAVER_START;
        else if (roll < 18)
            return OP_SAVER_STOP;
        else if (roll < 19)
            return OP_TICK;
        return OP_UNUSED;
    endfunction

    // idling mix per phase: none, sender only, receiver only, both
    int gap_mix   [NPHASE] = '{0, 53, 0, 23};
    int stall_mix [NPHASE] = '{0, 0, 53, 23};

    initial
    begin
        int n_ticks;
        int s;
        int phase;

        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;

        // --- directed table ---
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                if (!cfg_open)
                    settle();
                write_reg(plan[i].idx, plan[i].val);
            end
            else
                offer(plan[i].req, i);
        end
        foreach (tail_rows[i])
            offer(tail_rows[i].req, NPLAN + i);

        // --- random phases ---
        for (phase = 0; phase < NPHASE; phase++)
        begin
            settle();
            gap_pct   = gap_mix[phase];
            stall_pct = stall_mix[phase];

            // random short timeouts, now and then switched off
            for (s = 0; s < NSTAGE; s++)
                write_reg(reg_idx_t'(REG_DIM_TIMEOUT + s),
                          ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(1, 2)));
            write_reg(REG_LID_ACTIONS, 16'($urandom_range(63)));
            write_reg(REG_KEY_ACTION,  16'($urandom_range(7)));
            write_reg(REG_SAVER_LOCK,  16'($urandom_range(1)));

            // hold the receiver off while key requests keep coming, so the
            // block fills up and stalls its input
            if (phase == 0)
            begin
                hold_arm <= 1'b1;
                repeat (PRESSURE_REQS)
                    offer(random_req(OP_KEY), NO_ROW);
                while (hold_count < HOLD_LEN)
                    @(posedge clk);
            end

            // each event follows a short tick burst
            repeat (EVENTS_PER_PHASE)
            begin
                n_ticks = $urandom_range(3);
                repeat (n_ticks)
                    offer(random_req(OP_TICK), NO_ROW);
                offer(random_req(pick_op()), NO_ROW);
            end
        end

        settle();
        if (err_count == 0 && due_results.size() == 0)
            $display("idle_lid_power_key_policy_top verification clean");
        else
            $display("idle_lid_power_key_policy_top verification failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legitimate run.
    initial
    begin
        #10ms;
        $display("idle_lid_power_key_policy_top verification failed");
        $finish;
    end

endmodule
